// ----- hw/rtl/amw_pkg.sv -----
// Shared types, widths and codes for the accelerometer magnitude window unit.
// No dependencies; every other file imports this package.
package amw_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;

  localparam int OP_W       = 2;
  localparam int AXIS_W     = 16;
  localparam int SLOT_W     = 6;
  localparam int MAG_W      = 16;
  localparam int GRAV_W     = 15;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 34;  // sum of three squares of 16-bit magnitudes
  localparam int ROOT_W     = 17;
  localparam int PROD_W     = ROOT_W + SCALE_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 1'd1;
  localparam logic [GRAV_W-1:0]    GRAV_RESET  = 15'd16393;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd40159;

  // Multiplier operand selects
  localparam logic [1:0] MSEL_X     = 2'd0;
  localparam logic [1:0] MSEL_Y     = 2'd1;
  localparam logic [1:0] MSEL_Z     = 2'd2;
  localparam logic [1:0] MSEL_SCALE = 2'd3;

  // Accumulator modes
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_SET  = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_ROOT = 2'd3;

  localparam logic [SUM_W-1:0] ROOT_BIT_INIT = 34'h1_0000_0000;
  localparam logic [SUM_W-1:0] ROUND_HALF    = 34'd32768;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [SLOT_W-1:0]        read_slot;
  } amw_in_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic [SLOT_W-1:0] slot;
    logic              window_full;
  } amw_out_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] msel;
    logic [1:0] acc;
    logic       step;
  } amw_ctl_t;

endpackage

// ----- hw/rtl/amw_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on amw_pkg for the payload types.
interface amw_in_if import amw_pkg::*; ();
  logic    valid;
  logic    ready;
  amw_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface amw_out_if import amw_pkg::*; ();
  logic     valid;
  logic     ready;
  amw_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/accel_magnitude_window_unit.sv -----
// Sample item: 3 squares, 1 sum, 17 root steps, 1 scale, 1 store, in that order.
// Read item: a registered store read, then the store; clear and restart: the store alone.
// One item in flight; a finished result waits in the output register.
// Reset (async, active low) clears the sequencer, write index, full flag and
// restores both configuration registers; store contents are undefined until written.
module accel_magnitude_window_unit import amw_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  amw_in_if.sink                in_if,
  amw_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQZ   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [GRAV_W-1:0]  grav_q;
  logic [SCALE_W-1:0] scale_q;
  logic [OP_W-1:0]    op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               out_valid_q, out_valid_d;
  amw_out_t           out_q;

  amw_ctl_t           ctl;
  amw_out_t           res;
  logic               root_last;
  logic [MAG_W-1:0]   mag;
  logic               in_xfer;
  logic               out_free;
  logic               commit;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;
  assign commit      = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= GRAV_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRAVITY: grav_q  <= cfg_data_i[GRAV_W-1:0];
        REG_SCALE:   scale_q <= cfg_data_i[SCALE_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    unique case (state_q)
      S_IDLE: begin
        ctl.load = in_xfer;
        if (in_xfer) begin
          unique case (in_if.payload.operation) inside
            OP_SAMPLE:            state_d = S_SQX;
            OP_READ:              state_d = S_RD;
            OP_CLEAR, OP_RESTART: state_d = S_DONE;
          endcase
        end
      end
      S_SQX: begin
        ctl.mul  = 1'b1;
        ctl.msel = MSEL_X;
        state_d  = S_SQY;
      end
      S_SQY: begin
        ctl.mul  = 1'b1;
        ctl.msel = MSEL_Y;
        ctl.acc  = ACC_SET;
        state_d  = S_SQZ;
      end
      S_SQZ: begin
        ctl.mul  = 1'b1;
        ctl.msel = MSEL_Z;
        ctl.acc  = ACC_ADD;
        state_d  = S_ACC;
      end
      S_ACC: begin
        ctl.acc = ACC_ROOT;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        ctl.step = 1'b1;
        if (root_last) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        ctl.mul  = 1'b1;
        ctl.msel = MSEL_SCALE;
        state_d  = S_DONE;
      end
      S_RD: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= in_if.payload.operation;
      slot_q <= in_if.payload.read_slot;
    end
  end

  amw_dp u_dp (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .item_i      (in_if.payload),
    .grav_i      (grav_q),
    .scale_i     (scale_q),
    .root_last_o (root_last),
    .mag_o       (mag)
  );

  amw_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit),
    .op_i      (op_q),
    .mag_i     (mag),
    .rd_en_i   (state_q == S_RD),
    .rd_slot_i (slot_q),
    .res_o     (res)
  );

  // Hold the result until transfer; load the next one when the register frees
  assign out_valid_d = commit ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

endmodule

// ----- hw/rtl/amw_dp.sv -----
// Arithmetic datapath: one shared 17x16 multiplier, a 34-bit accumulator that
// doubles as the square root remainder, and a one-bit-per-cycle root step.
// Depends on amw_pkg.
module amw_dp import amw_pkg::*; (
  input  logic               clk_i,
  input  amw_ctl_t           ctl_i,
  input  amw_in_t            item_i,
  input  logic [GRAV_W-1:0]  grav_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               root_last_o,
  output logic [MAG_W-1:0]   mag_o
);

  logic [AXIS_W-1:0] ax_q, ay_q, az_q;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  rem_q, res_q, bit_q;

  logic signed [AXIS_W:0] dz;
  logic [ROOT_W-1:0]      mul_a;
  logic [SCALE_W-1:0]     mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [SUM_W-1:0]       trial;
  logic [SUM_W-1:0]       rnd;

  function automatic logic [AXIS_W-1:0] abs17(input logic signed [AXIS_W:0] v);
    logic signed [AXIS_W:0] n;
    n = -v;
    return v[AXIS_W] ? n[AXIS_W-1:0] : v[AXIS_W-1:0];
  endfunction

  assign dz = $signed({item_i.accel_z[AXIS_W-1], item_i.accel_z})
            - $signed({2'b00, grav_i});

  always_comb begin
    case (ctl_i.msel)
      MSEL_X: begin
        mul_a = {1'b0, ax_q};
        mul_b = ax_q;
      end
      MSEL_Y: begin
        mul_a = {1'b0, ay_q};
        mul_b = ay_q;
      end
      MSEL_Z: begin
        mul_a = {1'b0, az_q};
        mul_b = az_q;
      end
      default: begin
        mul_a = res_q[ROOT_W-1:0];
        mul_b = scale_i;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ax_q <= abs17($signed({item_i.accel_x[AXIS_W-1], item_i.accel_x}));
      ay_q <= abs17($signed({item_i.accel_y[AXIS_W-1], item_i.accel_y}));
      az_q <= abs17(dz);
    end
    if (ctl_i.mul) begin
      prod_q <= mul_p;
    end
    case (ctl_i.acc)
      ACC_SET: rem_q <= {1'b0, prod_q};
      ACC_ADD: rem_q <= rem_q + {1'b0, prod_q};
      ACC_ROOT: begin
        rem_q <= rem_q + {1'b0, prod_q};
        res_q <= '0;
        bit_q <= ROOT_BIT_INIT;
      end
      default: begin
        if (ctl_i.step) begin
          if (rem_q >= trial) begin
            rem_q <= rem_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
    endcase
  end

  // Last root step is the one with the lowest bit set
  assign root_last_o = bit_q[0];

  // Round to nearest, drop the Q16 fraction, saturate
  assign rnd   = {1'b0, prod_q} + ROUND_HALF;
  assign mag_o = (|rnd[SUM_W-1:SUM_W-2]) ? '1 : rnd[31:16];

endmodule

// ----- hw/rtl/amw_store.sv -----
// Window ring store with write index and full flag; forms the result fields.
// Depends on amw_pkg.
module amw_store import amw_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [MAG_W-1:0]  mag_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output amw_out_t          res_o
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);

  logic [MAG_W-1:0] mem_q [WINDOW_DEPTH];
  logic [MAG_W-1:0] rd_data_q;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic             full_q, full_d;

  logic [SLOT_W+IDX_W-1:0] rd_ext, wr_ext;
  logic [IDX_W-1:0]        rd_idx;
  logic [SLOT_W-1:0]       wr_slot;
  logic                    in_range;
  logic                    wrap;

  assign rd_ext   = {{IDX_W{1'b0}}, rd_slot_i};
  assign rd_idx   = rd_ext[IDX_W-1:0];
  assign wr_ext   = {{SLOT_W{1'b0}}, wr_idx_q};
  assign wr_slot  = wr_ext[SLOT_W-1:0];
  assign in_range = 32'(rd_slot_i) < 32'(WINDOW_DEPTH);
  assign wrap     = (wr_idx_q == IDX_W'(WINDOW_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (commit_i && op_i == OP_SAMPLE) begin
      mem_q[wr_idx_q] <= mag_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    full_d   = full_q;
    res_o    = '0;
    unique case (op_i)
      OP_SAMPLE: begin
        wr_idx_d = wrap ? '0 : wr_idx_q + 1'b1;
        full_d   = full_q | wrap;
        res_o.magnitude = mag_i;
        res_o.slot      = wr_slot;
      end
      OP_CLEAR: begin
        full_d     = 1'b0;
        res_o.slot = wr_slot;
      end
      OP_RESTART: begin
        wr_idx_d = '0;
        full_d   = 1'b0;
      end
      OP_READ: begin
        res_o.magnitude = in_range ? rd_data_q : '0;
        res_o.slot      = rd_slot_i;
      end
    endcase
    res_o.window_full = full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      full_q   <= 1'b0;
    end else if (commit_i) begin
      wr_idx_q <= wr_idx_d;
      full_q   <= full_d;
    end
  end

endmodule

// ----- hw/rtl/amw_chk.sv -----
// Port-level checks for accel_magnitude_window_unit, attached by bind.
// Depends on amw_pkg and the top-level port names.
module amw_chk import amw_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input amw_out_t out_payload_i
);

  // One item at a time: a transfer in drops ready in the cycle after it
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready right after a transfer");

  // A fresh result only appears as the sequencer returns to accept
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while sequencer busy");

  // A waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result changed or dropped");

endmodule

bind accel_magnitude_window_unit amw_chk u_amw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_payload_i (out_if.payload)
);

// ----- dv/amw_window_checker.sv -----
// Result checker for the accelerometer magnitude window unit: watches both channels
// and the register write port, predicts every result and compares it field by field.
// Depends on amw_pkg and the channel interfaces in amw_if.sv.
module amw_window_checker import amw_pkg::*; #(
  parameter int DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  amw_in_if                     in_mon,
  amw_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [GRAV_W-1:0]  gravity_q;
  logic [SCALE_W-1:0] scale_q;
  logic [MAG_W-1:0]   window_mem [DEPTH];
  int unsigned        wr_index;
  logic               full_q;
  amw_out_t           expected_results[$];
  amw_out_t           want;
  amw_out_t           got;

  function automatic logic [MAG_W-1:0] vector_magnitude(amw_in_t it,
                                                        logic [GRAV_W-1:0] grav,
                                                        logic [SCALE_W-1:0] scale);
    longint          ax;
    longint          ay;
    longint          az;
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned scaled;
    ax = longint'(it.accel_x);
    ay = longint'(it.accel_y);
    az = longint'(it.accel_z) - longint'(grav);
    sum_sq = ax * ax + ay * ay + az * az;
    // build the floor root one bit at a time, top bit first
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    scaled = (root * scale + 64'd32768) >> 16;
    return (scaled > 64'd65535) ? '1 : scaled[MAG_W-1:0];
  endfunction

  function automatic amw_out_t apply_item(amw_in_t it);
    amw_out_t res;
    res = '0;
    case (it.operation)
      OP_SAMPLE: begin
        res.magnitude = vector_magnitude(it, gravity_q, scale_q);
        window_mem[wr_index] = res.magnitude;
        res.slot = wr_index[SLOT_W-1:0];
        // wrap the ring and mark the window full
        if (wr_index == DEPTH - 1) begin
          wr_index = 0;
          full_q = 1'b1;
        end else begin
          wr_index++;
        end
      end
      OP_CLEAR: begin
        full_q = 1'b0;
        res.slot = wr_index[SLOT_W-1:0];
      end
      OP_RESTART: begin
        wr_index = 0;
        full_q = 1'b0;
      end
      OP_READ: begin
        res.slot = it.read_slot;
        // a slot past the window depth reads as zero
        if (it.read_slot < DEPTH) res.magnitude = window_mem[it.read_slot];
      end
    endcase
    res.window_full = full_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q = GRAV_RESET;
      scale_q = SCALE_RESET;
      wr_index = 0;
      full_q = 1'b0;
      fail_count_o = 0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_GRAVITY) gravity_q = cfg_data_i[GRAV_W-1:0];
        else if (cfg_idx_i == REG_SCALE) scale_q = cfg_data_i[SCALE_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) expected_results.push_back(apply_item(in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.magnitude !== want.magnitude) begin
            $display("%0t: magnitude expected %0d got %0d", $time, want.magnitude,
                     got.magnitude);
            fail_count_o++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
            fail_count_o++;
          end
          if (got.window_full !== want.window_full) begin
            $display("%0t: window_full expected %0b got %0b", $time, want.window_full,
                     got.window_full);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- dv/tb_accel_magnitude_window_unit.sv -----
// Top of the accelerometer magnitude window testbench: clock, reset, register writes,
// sample, read, clear and restart traffic with idle and stall phases, and the final verdict.
// Depends on amw_pkg, amw_if.sv, the unit itself and amw_window_checker.
module tb_accel_magnitude_window_unit import amw_pkg::*; ();

  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 272;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 600000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycle_count   = 0;
  int                    in_idle_pct   = 0;
  int                    out_stall_pct = 0;
  int                    hold_asks     = 0;
  int                    hold_done     = 0;

  // slot bookkeeping so that reads only hit written entries
  logic [GRAV_W-1:0]           cur_grav      = GRAV_RESET;
  logic [WINDOW_DEPTH_DEF-1:0] written_slots = '0;
  int                          track_index   = 0;
  int                          last_slot     = 0;

  amw_in_if  in_ch ();
  amw_out_if out_ch ();

  accel_magnitude_window_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH_DEF)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  amw_window_checker #(
    .DEPTH(WINDOW_DEPTH_DEF)
  ) u_window_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_accel_magnitude_window_unit NOT OK");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  function automatic amw_in_t make_item(logic [OP_W-1:0] op, int x, int y, int z, int rs);
    amw_in_t it;
    it.operation = op;
    it.accel_x = 16'(x);
    it.accel_y = 16'(y);
    it.accel_z = 16'(z);
    it.read_slot = 6'(rs);
    return it;
  endfunction

  function automatic int extreme_axis();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic amw_in_t gen_random_item();
    amw_in_t it;
    int      pick;
    int      rz;
    int      rs;
    pick = $urandom_range(99);
    it.accel_x = 16'($urandom);
    it.accel_y = 16'($urandom);
    it.accel_z = 16'($urandom);
    it.read_slot = 6'($urandom);
    // mostly samples so the ring wraps often; restarts stay rare
    if (pick < 71 || written_slots == '0) it.operation = OP_SAMPLE;
    else if (pick < 91) it.operation = OP_READ;
    else if (pick < 99) it.operation = OP_CLEAR;
    else it.operation = OP_RESTART;
    case ($urandom_range(9))
      5, 6, 7: begin
        // device near rest: small X/Y, Z close to one g
        rz = int'(cur_grav) + int'($urandom_range(4000)) - 2000;
        if (rz > 32767) rz = 32767;
        it.accel_x = 16'(int'($urandom_range(4000)) - 2000);
        it.accel_y = 16'(int'($urandom_range(4000)) - 2000);
        it.accel_z = 16'(rz);
      end
      8: begin
        it.accel_x = 16'(extreme_axis());
        it.accel_y = 16'(extreme_axis());
        it.accel_z = 16'(extreme_axis());
      end
      9: it.accel_z = 16'(cur_grav);
      default: ;
    endcase
    if (it.operation == OP_READ) begin
      rs = $urandom_range(WINDOW_DEPTH_DEF - 1);
      if (!written_slots[rs]) rs = last_slot;
      it.read_slot = 6'(rs);
    end
    return it;
  endfunction

  task automatic send_item(input amw_in_t it);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    // follow the write index the same way the unit does
    if (it.operation == OP_SAMPLE) begin
      written_slots[track_index] = 1'b1;
      last_slot = track_index;
      track_index = (track_index + 1) % WINDOW_DEPTH_DEF;
    end else if (it.operation == OP_RESTART) begin
      track_index = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_unit();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) drain_unit();
      case (ph)
        1: begin
          cur_grav = '0;
          write_reg(REG_GRAVITY, 16'(cur_grav));
          write_reg(REG_SCALE, 16'hFFFF);
          in_idle_pct = 51;
          out_stall_pct = 0;
        end
        2: begin
          cur_grav = 15'h7FFF;
          write_reg(REG_GRAVITY, 16'(cur_grav));
          write_reg(REG_SCALE, 16'hFFFF);
          in_idle_pct = 0;
          out_stall_pct = 51;
        end
        3: begin
          cur_grav = 15'($urandom);
          write_reg(REG_GRAVITY, 16'(cur_grav));
          write_reg(REG_SCALE, 16'h0000);
          in_idle_pct = 24;
          out_stall_pct = 24;
        end
        4: begin
          cur_grav = 15'($urandom);
          write_reg(REG_GRAVITY, 16'(cur_grav));
          write_reg(REG_SCALE, 16'($urandom));
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        default: ;
      endcase

      // largest possible vector, then one that cancels gravity exactly
      send_item(make_item(OP_SAMPLE, -32768, -32768, -32768, 0));
      send_item(make_item(OP_SAMPLE, 0, 0, int'(cur_grav), 63));

      if (ph == 0) begin
        send_item(make_item(OP_SAMPLE, 32767, 32767, 32767, 0));
        send_item(make_item(OP_SAMPLE, 1, -1, int'(cur_grav) - 1, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0));
        send_item(make_item(OP_READ, -1, -1, -1, 2));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_RESTART, 0, 0, 0, 0));
        send_item(make_item(OP_SAMPLE, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 3));
        send_item(make_item(OP_SAMPLE, -32768, 32767, 0, 0));
        send_item(make_item(OP_CLEAR, -1, -1, -1, 63));
        send_item(make_item(OP_RESTART, -1, -1, -1, 63));
        send_item(make_item(OP_READ, 32767, -32768, 32767, 1));
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the result side back up so the input stalls
        if (ph == 2 && n == 20) hold_asks++;
        send_item(gen_random_item());
      end
    end

    drain_unit();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_accel_magnitude_window_unit OK");
    end else begin
      $display("tb_accel_magnitude_window_unit NOT OK");
    end
    $finish;
  end

endmodule
